// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i with reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every clock edge outside reset.
`define SVQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SVQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/svq_pkg.sv -----
// ----------------------------------------------------------------------------
// svq_pkg
// Types, codes and sizing constants of the split virtqueue descriptor engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svq_pkg;

  localparam int unsigned MAX_QUEUE_ENTRIES = 256;

  // Exponent of the largest power of two not above the argument.
  function automatic int unsigned floor_log2(input int unsigned v);
    int unsigned r;
    r = 0;
    for (int i = 0; i < 32; i++) begin
      if ((v >> i) != 0) r = i;
    end
    return r;
  endfunction

  // The size register saturates at 256 entries.
  localparam int unsigned QS_LG_MAX =
      (floor_log2(MAX_QUEUE_ENTRIES) > 8) ? 8 : floor_log2(MAX_QUEUE_ENTRIES);
  localparam int unsigned AW    = (QS_LG_MAX > 0) ? QS_LG_MAX : 1;
  localparam int unsigned DEPTH = 1 << AW;

  localparam logic [8:0]  QS_RESET = 9'(1 << QS_LG_MAX);
  localparam logic [15:0] LINK_END = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_POST = 2'd1,
    MODE_GET  = 2'd2,
    MODE_FREE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_RANGE   = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Write request into the descriptor table.
  typedef struct packed {
    logic          link_we;
    logic [AW-1:0] idx;
    logic [15:0]   link;
    logic          desc_we;
    logic [63:0]   addr;
    logic [31:0]   len;
    logic          wflag;
  } tbl_wr_t;

  // Queue size in entries for a value of the size register.
  function automatic logic [8:0] qsize(input logic [3:0] lg);
    logic [3:0] lg_eff;
    lg_eff = (lg > 4'(QS_LG_MAX)) ? 4'(QS_LG_MAX) : lg;
    return 9'd1 << lg_eff;
  endfunction

endpackage

// ----- hw/rtl/split_virtqueue_descriptor_engine.sv -----
// ----------------------------------------------------------------------------
// split_virtqueue_descriptor_engine
// Split virtqueue bookkeeping: descriptor free list, avail ring and used ring.
// ----------------------------------------------------------------------------
// In the cycle an item is accepted the engine issues reads of the descriptor
// link memory at the free-list head and of the used ring at the consume slot;
// in the next cycle the registered read data is available and the operation is
// decided; once the output register is free the memories are written and the
// result is loaded into the output register. The synchronous read of the link
// memory ahead of the head update is why an item needs a separate execute
// state. A result that waits in the output register does not keep the next
// item out; only the commit of that next item waits until the output register
// is free. A queue size write rebuilds the free chain at once, since the link
// entries carry valid bits that are cleared at once; there is no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module split_virtqueue_descriptor_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: queue size log2.
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  // Input item channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [63:0] buf_addr_i,
  input  logic [31:0] buf_len_i,
  input  logic        device_writes_i,
  input  logic [7:0]  desc_index_i,
  input  logic [31:0] done_len_i,
  // Result item channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  result_index_o,
  output logic [31:0] result_len_o,
  output logic [8:0]  free_count_o,
  output logic [15:0] avail_published_o,
  output logic        used_pending_o
);
  import svq_pkg::*;

  // Control state.
  state_e      state_q, state_d;
  logic        commit;
  logic        in_acc;

  // Queue bookkeeping registers.
  logic [8:0]  qs_q;
  logic [15:0] head_q, head_d;
  logic [8:0]  free_q, free_d;
  logic [15:0] avail_cnt_q, avail_cnt_d;
  logic [15:0] used_cnt_q, used_cnt_d;
  logic [15:0] cons_cnt_q, cons_cnt_d;

  // Captured input item.
  mode_e       mode_q;
  logic [63:0] addr_q;
  logic [31:0] len_q;
  logic        wflag_q;
  logic [7:0]  idx_q;
  logic [31:0] dlen_q;

  // Output register.
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [7:0]  rindex_q;
  logic [31:0] rlen_q;
  logic [8:0]  fcount_q;
  logic [15:0] avail_pub_q;
  logic        pending_q;

  // Datapath.
  logic [8:0]  mask;
  logic [15:0] pending;
  logic [15:0] link_val;
  logic [39:0] used_rdata;
  status_e     status_c;
  logic [7:0]  rindex_c;
  logic [31:0] rlen_c;
  logic        avail_we;
  logic        used_we;
  tbl_wr_t     tbl_wr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mask       = qs_q - 9'd1;
  assign pending    = used_cnt_q - cons_cnt_q;

  // Sequencer: read on acceptance, commit once the output register can load.
  always_comb begin
    state_d = state_q;
    commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!out_valid_q || !out_stall_i) begin
          commit  = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= mode_e'(mode_i);
      addr_q  <= buf_addr_i;
      len_q   <= buf_len_i;
      wflag_q <= device_writes_i;
      idx_q   <= desc_index_i;
      dlen_q  <= done_len_i;
    end
  end

  svq_desc_table u_desc_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (cfg_we_i),
    .qsize_i  (qs_q),
    .rd_en_i  (in_acc),
    .rd_idx_i (head_q[AW-1:0]),
    .wr_i     (tbl_wr),
    .link_o   (link_val)
  );

  // The avail ring is published for the device and not read back here.
  svq_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_avail_ram (
    .clk_i   (clk_i),
    .we_i    (avail_we),
    .waddr_i (avail_cnt_q[AW-1:0] & mask[AW-1:0]),
    .wdata_i (head_q[7:0]),
    .re_i    (1'b0),
    .raddr_i ('0),
    .rdata_o ()
  );

  // Used ring entries hold the descriptor id above the used length.
  svq_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_cnt_q[AW-1:0] & mask[AW-1:0]),
    .wdata_i ({idx_q, dlen_q}),
    .re_i    (in_acc),
    .raddr_i (cons_cnt_q[AW-1:0] & mask[AW-1:0]),
    .rdata_o (used_rdata)
  );

  // Operation decode and state update, evaluated in the execute cycle.
  always_comb begin
    head_d      = head_q;
    free_d      = free_q;
    avail_cnt_d = avail_cnt_q;
    used_cnt_d  = used_cnt_q;
    cons_cnt_d  = cons_cnt_q;
    status_c    = STAT_OK;
    rindex_c    = '0;
    rlen_c      = '0;
    avail_we    = 1'b0;
    used_we     = 1'b0;
    tbl_wr      = '{link_we: 1'b0, idx: head_q[AW-1:0], link: '0, desc_we: 1'b0,
                    addr: addr_q, len: len_q, wflag: wflag_q};
    unique case (mode_q)
      MODE_ADD: begin
        // An empty list, or a head off the end of the chain, refuses the add.
        if (free_q == 9'd0 || head_q >= 16'(qs_q)) begin
          status_c = STAT_NO_FREE;
        end else begin
          head_d         = link_val;
          free_d         = free_q - 9'd1;
          avail_cnt_d    = avail_cnt_q + 16'd1;
          rindex_c       = head_q[7:0];
          avail_we       = commit;
          tbl_wr.link_we = commit;
          tbl_wr.desc_we = commit;
        end
      end
      MODE_POST: begin
        if (9'(idx_q) >= qs_q) begin
          status_c = STAT_RANGE;
        end else if (pending >= 16'(qs_q)) begin
          status_c = STAT_NO_FREE;
        end else begin
          used_cnt_d = used_cnt_q + 16'd1;
          used_we    = commit;
        end
      end
      MODE_GET: begin
        if (pending == 16'd0) begin
          status_c = STAT_EMPTY;
        end else begin
          rindex_c   = used_rdata[39:32];
          rlen_c     = used_rdata[31:0];
          cons_cnt_d = cons_cnt_q + 16'd1;
        end
      end
      MODE_FREE: begin
        // Freeing while every descriptor is already free is refused too.
        if (9'(idx_q) >= qs_q || free_q >= qs_q) begin
          status_c = STAT_RANGE;
        end else begin
          tbl_wr.idx     = idx_q[AW-1:0];
          tbl_wr.link    = head_q;
          tbl_wr.link_we = commit;
          head_d         = 16'(idx_q);
          free_d         = free_q + 9'd1;
        end
      end
    endcase
  end

  // A queue size write rebuilds the chain and clears all ring counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qs_q        <= QS_RESET;
      head_q      <= '0;
      free_q      <= QS_RESET;
      avail_cnt_q <= '0;
      used_cnt_q  <= '0;
      cons_cnt_q  <= '0;
    end else if (cfg_we_i) begin
      qs_q        <= qsize(cfg_wdata_i);
      head_q      <= '0;
      free_q      <= qsize(cfg_wdata_i);
      avail_cnt_q <= '0;
      used_cnt_q  <= '0;
      cons_cnt_q  <= '0;
    end else if (commit) begin
      head_q      <= head_d;
      free_q      <= free_d;
      avail_cnt_q <= avail_cnt_d;
      used_cnt_q  <= used_cnt_d;
      cons_cnt_q  <= cons_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q    <= status_c;
      rindex_q    <= rindex_c;
      rlen_q      <= rlen_c;
      fcount_q    <= free_d;
      avail_pub_q <= avail_cnt_d;
      pending_q   <= (used_cnt_d != cons_cnt_d);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign result_index_o    = rindex_q;
  assign result_len_o      = rlen_q;
  assign free_count_o      = fcount_q;
  assign avail_published_o = avail_pub_q;
  assign used_pending_o    = pending_q;

  // The free count never exceeds the queue size.
  `SVQ_ASSERT(a_free_bound, free_q <= qs_q, "free count above queue size")
  // Outstanding used entries never exceed the queue size.
  `SVQ_ASSERT(a_pending_bound, pending <= 16'(qs_q), "used ring overfilled")
  // A committed item is presented at the output in the next cycle.
  `SVQ_ASSERT_NEXT(a_commit_out, commit, out_valid_o, "committed result not presented")
  // An accepted item moves the sequencer into its execute cycle.
  `SVQ_ASSERT_NEXT(a_acc_exec, in_acc, state_q == ST_EXEC, "accepted item not executed")

endmodule

// ----- hw/rtl/svq_ram.sv -----
// ----------------------------------------------------------------------------
// svq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned RAW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [RAW-1:0]   waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [RAW-1:0]   raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/svq_desc_table.sv -----
// ----------------------------------------------------------------------------
// svq_desc_table
// Descriptor table: buffer fields and the free-list link words, with per-entry
// valid bits so that an unwritten link reads as its rebuilt chain value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svq_desc_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic [8:0]           qsize_i,
  input  logic                 rd_en_i,
  input  logic [svq_pkg::AW-1:0] rd_idx_i,
  input  svq_pkg::tbl_wr_t     wr_i,
  output logic [15:0]          link_o
);
  import svq_pkg::*;

  logic [DEPTH-1:0] vld_q;
  logic [AW-1:0]    idx_q;
  logic [15:0]      link_raw;
  logic [15:0]      link_dflt;

  svq_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.link_we),
    .waddr_i (wr_i.idx),
    .wdata_i (wr_i.link),
    .re_i    (rd_en_i),
    .raddr_i (rd_idx_i),
    .rdata_o (link_raw)
  );

  // Address, length and direction are kept for the device side.
  svq_ram #(.WIDTH(97), .DEPTH(DEPTH)) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.desc_we),
    .waddr_i (wr_i.idx),
    .wdata_i ({wr_i.addr, wr_i.len, wr_i.wflag}),
    .re_i    (1'b0),
    .raddr_i ('0),
    .rdata_o ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_i.link_we) begin
      vld_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      idx_q <= rd_idx_i;
    end
  end

  // A rebuilt chain links each entry to the next and ends at the last entry.
  assign link_dflt = (9'(idx_q) == qsize_i - 9'd1) ? LINK_END : 16'(idx_q) + 16'd1;
  assign link_o    = vld_q[idx_q] ? link_raw : link_dflt;

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the split virtqueue descriptor engine. A local model
// of the descriptor free list, avail counter and used ring predicts the result
// of every accepted item. Directed cases come first, then randomized
// driver/device traffic over several queue sizes, with random idling on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import svq_pkg::*;

  // Limit on idle cycles; a run with no handshake on either channel that long is hung.
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    mode_e       mode;
    logic [63:0] addr;
    logic [31:0] len;
    logic        wr;
    logic [7:0]  idx;
    logic [31:0] dlen;
  } ring_op_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  index;
    logic [31:0] rlen;
    logic [8:0]  free_cnt;
    logic [15:0] avail;
    logic        pending;
  } ring_rsp_t;

  // Every input is held at a known value from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = 4'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = 2'd0;
  logic [63:0] buf_addr_i = 64'd0;
  logic [31:0] buf_len_i = 32'd0;
  logic        device_writes_i = 1'b0;
  logic [7:0]  desc_index_i = 8'd0;
  logic [31:0] done_len_i = 32'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  result_index_o;
  logic [31:0] result_len_o;
  logic [8:0]  free_count_o;
  logic [15:0] avail_published_o;
  logic        used_pending_o;

  split_virtqueue_descriptor_engine dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .buf_addr_i        (buf_addr_i),
    .buf_len_i         (buf_len_i),
    .device_writes_i   (device_writes_i),
    .desc_index_i      (desc_index_i),
    .done_len_i        (done_len_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .result_index_o    (result_index_o),
    .result_len_o      (result_len_o),
    .free_count_o      (free_count_o),
    .avail_published_o (avail_published_o),
    .used_pending_o    (used_pending_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the engine. Only state that can show up in a result is kept:
  // buffer address, length and the write flag are stored by the engine but
  // never read back, so they are not tracked here.
  // --------------------------------------------------------------------------
  logic [3:0]  size_lg;
  int unsigned ring_entries;
  logic [15:0] link_mem [MAX_QUEUE_ENTRIES];
  logic [15:0] chain_head;
  int unsigned free_left;
  logic [15:0] avail_idx;
  logic [7:0]  used_ids [MAX_QUEUE_ENTRIES];
  logic [31:0] used_lens [MAX_QUEUE_ENTRIES];
  logic [15:0] posted_idx;
  logic [15:0] reaped_idx;

  // Results still owed by the engine, oldest first.
  ring_rsp_t awaited_results [$];

  // Descriptors the driver side has handed out and not yet seen completed,
  // and descriptors whose completion was reaped and which can be returned.
  logic [7:0] to_post [$];
  logic [7:0] to_free [$];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned drain_hold = 0;
  bit          quiet_feed = 1'b0;
  bit          quiet_drain = 1'b0;

  // The size register saturates at eight, that is at the full table.
  function automatic int unsigned entries_for(input logic [3:0] lg);
    return (lg >= 4'd8) ? MAX_QUEUE_ENTRIES : (1 << lg);
  endfunction

  // A size write relinks the entries below the new size in order and clears
  // all ring counters. Entries above the new size are left as they are.
  function automatic void ring_rebuild();
    ring_entries = entries_for(size_lg);
    for (int i = 0; i < ring_entries; i++) begin
      link_mem[i] = 16'(i + 1);
    end
    link_mem[ring_entries - 1] = LINK_END;
    chain_head = 16'd0;
    free_left  = ring_entries;
    avail_idx  = 16'd0;
    posted_idx = 16'd0;
    reaped_idx = 16'd0;
  endfunction

  // Applies one item to the model and returns the result it must produce.
  function automatic ring_rsp_t predict_ring_op(input ring_op_t op);
    ring_rsp_t   r;
    logic [15:0] backlog;
    logic [15:0] id;
    int unsigned slot;
    r = '0;
    r.status = STAT_OK;
    backlog = posted_idx - reaped_idx;
    case (op.mode)
      MODE_ADD: begin
        id = chain_head;
        // A head past the queue (the end marker included) while the count
        // claims free entries means the chain has been corrupted by double
        // frees; the add is refused and nothing moves.
        if (free_left == 0 || id >= ring_entries) begin
          r.status = STAT_NO_FREE;
        end else begin
          chain_head = link_mem[id];
          free_left--;
          link_mem[id] = 16'd0;
          avail_idx++;
          r.index = id[7:0];
        end
      end
      MODE_POST: begin
        if (op.idx >= ring_entries) begin
          r.status = STAT_RANGE;
        end else if (backlog >= ring_entries) begin
          r.status = STAT_NO_FREE;
        end else begin
          slot = posted_idx % ring_entries;
          used_ids[slot]  = op.idx;
          used_lens[slot] = op.dlen;
          posted_idx++;
        end
      end
      MODE_GET: begin
        if (backlog == 16'd0) begin
          r.status = STAT_EMPTY;
        end else begin
          slot = reaped_idx % ring_entries;
          r.index = used_ids[slot];
          r.rlen  = used_lens[slot];
          reaped_idx++;
        end
      end
      default: begin
        // A free is refused when the index is past the queue or when the
        // count says every descriptor is already free.
        if (op.idx >= ring_entries || free_left >= ring_entries) begin
          r.status = STAT_RANGE;
        end else begin
          link_mem[op.idx] = chain_head;
          chain_head = 16'(op.idx);
          free_left++;
        end
      end
    endcase
    backlog = posted_idx - reaped_idx;
    r.free_cnt = 9'(free_left);
    r.avail    = avail_idx;
    r.pending  = (backlog != 16'd0);
    return r;
  endfunction

  initial begin
    size_lg = 4'd8;
    ring_rebuild();
  end

  // --------------------------------------------------------------------------
  // Result side. One process stalls the result channel for a random number of
  // cycles per item and checks each accepted result against the oldest
  // prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    ring_rsp_t want;
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (awaited_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, expected nothing, actual status %0h",
                 $time, status_o);
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 64'(want.status), 64'(status_o));
        check_field("result_index", 64'(want.index), 64'(result_index_o));
        check_field("result_len", 64'(want.rlen), 64'(result_len_o));
        check_field("free_count", 64'(want.free_cnt), 64'(free_count_o));
        check_field("avail_published", 64'(want.avail), 64'(avail_published_o));
        check_field("used_pending", 64'(want.pending), 64'(used_pending_o));
      end
      // Stall count for the next result; it only runs down while that
      // result is actually on offer, so every stall lands on a valid cycle.
      drain_hold = quiet_drain ? 0 : $urandom_range(0, 12);
      out_stall_i <= (drain_hold != 0);
    end else if (out_valid_o === 1'b1 && out_stall_i === 1'b1) begin
      if (drain_hold > 0) drain_hold--;
      if (drain_hold == 0) out_stall_i <= 1'b0;
    end
  end

  // Any handshake on either channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. All tasks are entered just after a rising edge.
  // --------------------------------------------------------------------------
  function automatic ring_op_t make_op(input mode_e m, input logic [63:0] a,
                                       input logic [31:0] l, input logic w,
                                       input logic [7:0] i, input logic [31:0] d);
    ring_op_t op;
    op.mode = m;
    op.addr = a;
    op.len  = l;
    op.wr   = w;
    op.idx  = i;
    op.dlen = d;
    return op;
  endfunction

  // Offers one item after a random gap, waits for it to be taken and queues
  // the prediction. Valid stays high afterwards so back-to-back items need no
  // extra edge; the next gap or a drain pause lowers it.
  task automatic issue_op(input ring_op_t op, output ring_rsp_t rsp);
    int unsigned gap;
    gap = quiet_feed ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i          <= op.mode;
    buf_addr_i      <= op.addr;
    buf_len_i       <= op.len;
    device_writes_i <= op.wr;
    desc_index_i    <= op.idx;
    done_len_i      <= op.dlen;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    rsp = predict_ring_op(op);
    awaited_results.push_back(rsp);
  endtask

  // Holds the input side until every owed result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // Size writes happen only with the engine idle, once every owed result is back.
  task automatic set_queue_size(input logic [3:0] lg);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_wdata_i <= lg;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_lg = lg;
    ring_rebuild();
    to_post.delete();
    to_free.delete();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset size (full table): empty used ring, free with everything free,
  // field extremes through add, post and get.
  task automatic test_reset_state();
    ring_rsp_t rsp;
    issue_op(make_op(MODE_GET, '0, '0, 1'b0, 8'd0, '0), rsp);
    issue_op(make_op(MODE_FREE, '0, '0, 1'b0, 8'd0, '0), rsp);
    issue_op(make_op(MODE_ADD, '1, '1, 1'b1, 8'hFF, '1), rsp);
    issue_op(make_op(MODE_ADD, '0, '0, 1'b0, 8'd0, '0), rsp);
    issue_op(make_op(MODE_POST, 64'hA5A5_5A5A_0F0F_F0F0, 32'h1234_5678, 1'b1,
                     8'hFF, 32'hFFFF_FFFF), rsp);
    issue_op(make_op(MODE_GET, '0, '0, 1'b0, 8'd0, '0), rsp);
    issue_op(make_op(MODE_FREE, '0, '0, 1'b0, 8'd1, '0), rsp);
  endtask

  // Two-entry queue: out-of-range free and post, then a post into a full
  // used ring.
  task automatic test_small_ring();
    ring_rsp_t rsp;
    set_queue_size(4'd1);
    issue_op(make_op(MODE_ADD, 64'h8000_0000_0000_0001, 32'h8000_0001, 1'b1,
                     8'd0, '0), rsp);
    issue_op(make_op(MODE_FREE, '0, '0, 1'b0, 8'd200, '0), rsp);
    issue_op(make_op(MODE_POST, '0, '0, 1'b0, 8'd2, 32'd7), rsp);
    issue_op(make_op(MODE_POST, '0, '0, 1'b0, 8'd0, 32'd0), rsp);
    issue_op(make_op(MODE_POST, '0, '0, 1'b0, 8'd1, 32'h8000_0000), rsp);
    issue_op(make_op(MODE_POST, '0, '0, 1'b0, 8'd0, 32'd99), rsp);
    issue_op(make_op(MODE_GET, '0, '0, 1'b0, 8'd0, '0), rsp);
  endtask

  // Four-entry queue. Repeated frees of the same descriptor inflate the
  // count past the real chain, so the chain runs out into the end marker
  // while the count still says one entry is free.
  task automatic test_broken_chain();
    ring_rsp_t rsp;
    set_queue_size(4'd2);
    repeat (4) begin
      issue_op(make_op(MODE_ADD, {$urandom, $urandom}, $urandom, 1'b0, 8'd0, '0), rsp);
    end
    issue_op(make_op(MODE_FREE, '0, '0, 1'b0, 8'd0, '0), rsp);
    repeat (3) issue_op(make_op(MODE_FREE, '0, '0, 1'b0, 8'd1, '0), rsp);
    repeat (4) begin
      issue_op(make_op(MODE_ADD, {$urandom, $urandom}, $urandom, 1'b1, 8'd0, '0), rsp);
    end
  endtask

  // One random item. Most follow the normal life of a buffer (add, device
  // completion, reap, free) with random contents; the rest are fully random
  // and bring out-of-range indexes, double frees and stray completions.
  task automatic random_op(input int unsigned add_weight);
    ring_op_t    op;
    ring_rsp_t   rsp;
    int          pick;
    int unsigned roll;
    op.mode = mode_e'($urandom_range(0, 3));
    op.addr = {$urandom, $urandom};
    op.len  = $urandom;
    op.wr   = 1'($urandom_range(0, 1));
    op.idx  = 8'($urandom_range(0, 255));
    op.dlen = $urandom;
    pick = -1;
    if ($urandom_range(0, 99) >= 12) begin
      roll = $urandom_range(0, 99);
      op.mode = MODE_ADD;
      if (roll >= add_weight) begin
        case (roll % 3)
          0: begin
            if (to_post.size() != 0) begin
              pick = $urandom_range(0, to_post.size() - 1);
              op.mode = MODE_POST;
              op.idx  = to_post[pick];
            end
          end
          1: op.mode = MODE_GET;
          default: begin
            if (to_free.size() != 0) begin
              pick = $urandom_range(0, to_free.size() - 1);
              op.mode = MODE_FREE;
              op.idx  = to_free[pick];
            end
          end
        endcase
      end
    end
    issue_op(op, rsp);
    case (op.mode)
      MODE_ADD: if (rsp.status == STAT_OK) to_post.push_back(rsp.index);
      MODE_POST: if (pick >= 0 && rsp.status == STAT_OK) to_post.delete(pick);
      MODE_GET: if (rsp.status == STAT_OK) to_free.push_back(rsp.index);
      default: if (pick >= 0) to_free.delete(pick);
    endcase
  endtask

  // Random traffic over a list of sizes that covers the smallest queue, the
  // full table and register values above eight, which saturate.
  task automatic test_random_traffic();
    logic [3:0]  plan [14];
    int unsigned count;
    int unsigned add_weight;
    plan = '{4'd0, 4'd3, 4'd15, 4'd1, 4'd5, 4'd8, 4'd2, 4'd9, 4'd4, 4'd7, 4'd6,
             4'd12, 4'd1, 4'd3};
    for (int p = 0; p < 14; p++) begin
      set_queue_size(plan[p]);
      quiet_feed  = ($urandom_range(0, 3) == 0);
      quiet_drain = ($urandom_range(0, 3) == 0);
      add_weight  = $urandom_range(25, 55);
      count = (ring_entries >= 64) ? 180 : 90;
      for (int n = 0; n < count; n++) begin
        // Now and then the driver holds off until everything has come back.
        if ($urandom_range(0, 39) == 0) wait_drained();
        random_op(add_weight);
      end
    end
  endtask

  initial begin : run
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_small_ring();
    test_broken_chain();
    test_random_traffic();
    wait_drained();
    // Any stray result would show up within a few cycles of the last one.
    repeat (8) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
